// ===== hdl/sparse_dot_nearest_centroid_defines.svh =====
// assertion macros for the sparse dot product nearest centroid block
`ifndef SPARSE_DOT_NEAREST_CENTROID_DEFINES_SVH
`define SPARSE_DOT_NEAREST_CENTROID_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SDNC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdnc check failed");

// antecedent implies consequent in the next cycle
`define SDNC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdnc check failed");

`endif

// ===== hdl/sdnc_pkg.sv =====
// shared constants for the sparse dot product nearest centroid block
`timescale 1ns / 1ps
`default_nettype none
package sdnc_pkg;
    localparam int MAX_POSTINGS = 4096;
    localparam int MAX_CLUSTERS = 256;
    localparam int POST_AW      = $clog2(MAX_POSTINGS);
    localparam int FILL_W       = POST_AW + 1;
    localparam int CLUS_AW      = $clog2(MAX_CLUSTERS);
    localparam int TERM_W       = 20;
    localparam int IMP_W        = 16;
    localparam int CLW          = 8;
    localparam int CNT_W        = 9;
    localparam int SCORE_W      = 48;
    localparam int PROD_W       = 2 * IMP_W;
    localparam int ENTRY_W      = TERM_W + CLW + IMP_W;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_TERM  = 2'd2;

    localparam logic REG_NUM_CLUSTERS = 1'b0;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_LIMIT = CNT_W'(MAX_CLUSTERS);
endpackage
`default_nettype wire

// ===== hdl/sparse_dot_nearest_centroid.sv =====
// sparse dot product nearest centroid assignment, top level
// channel | direction | signals
// in      | request   | in_valid in_ready cmd term_id impact cluster last
// out     | result    | out_valid out_ready win_cluster win_score matched load_error
// apb     | config    | psel penable pwrite paddr pwdata prdata pready
// clear, load and unused requests are handled in idle without leaving it; no wait in idle
// a term runs a binary search over the posting memory port (S_SEARCH, S_SWAIT per step),
// then reads each posting looked at (S_MRD, S_MCHK) and adds S_ACC per matching in-use posting
// a last term adds a scan (S_SCAN_RD, S_SCAN_CMP per cluster in use) over the score memory port
// reset clears control state and touched bits; the result register parts the channels
`timescale 1ns / 1ps
`default_nettype none
module sparse_dot_nearest_centroid (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    cmd,
    input  wire logic [sdnc_pkg::TERM_W-1:0]   term_id,
    input  wire logic [sdnc_pkg::IMP_W-1:0]    impact,
    input  wire logic [sdnc_pkg::CLW-1:0]      cluster,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sdnc_pkg::CLW-1:0]           win_cluster,
    output logic [sdnc_pkg::SCORE_W-1:0]       win_score,
    output logic                               matched,
    output logic                               load_error,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sdnc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [sdnc_pkg::PDATA_W-1:0]  pwdata,
    output logic [sdnc_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import sdnc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_SWAIT, S_MRD, S_MCHK, S_ACC, S_END,
        S_SCAN_RD, S_SCAN_CMP, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic                   err_reg;
    logic [TERM_W-1:0]      last_term_reg;
    logic [TERM_W-1:0]      term_reg;
    logic [IMP_W-1:0]       imp_reg;
    logic                   last_reg;
    logic [FILL_W-1:0]      lo_reg;
    logic [FILL_W-1:0]      hi_reg;
    logic [FILL_W-1:0]      mid_reg;
    logic [FILL_W-1:0]      pos_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [CLW-1:0]         clus_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic                   found_reg;
    logic [CLW-1:0]         best_c_reg;
    logic [SCORE_W-1:0]     best_s_reg;
    logic [MAX_CLUSTERS-1:0] touched_reg;
    logic                   out_valid_reg;
    logic [CLW-1:0]         out_c_reg;
    logic [SCORE_W-1:0]     out_s_reg;
    logic                   out_m_reg;
    logic                   out_e_reg;

    logic [ENTRY_W-1:0]     store_mem [MAX_POSTINGS];
    logic [ENTRY_W-1:0]     store_q;
    logic                   st_re;
    logic [POST_AW-1:0]     st_raddr;
    logic                   st_we;
    logic [SCORE_W-1:0]     score_mem [MAX_CLUSTERS];
    logic [SCORE_W-1:0]     score_q;
    logic                   sc_re;
    logic [CLUS_AW-1:0]     sc_raddr;
    logic                   sc_we;
    logic [SCORE_W-1:0]     sc_wdata;

    logic                   in_acc;
    logic                   cfg_wr;
    logic [CNT_W-1:0]       limit;
    logic [FILL_W:0]        mid_sum;
    logic [FILL_W-1:0]      mid_next;
    logic [TERM_W-1:0]      q_term;
    logic [CLW-1:0]         q_clus;
    logic [IMP_W-1:0]       q_imp;
    logic [SCORE_W-1:0]     base;
    logic [SCORE_W:0]       sum;
    logic                   out_free;

    assign in_acc   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_NUM_CLUSTERS) ? PDATA_W'(count_reg) : '0;
    assign limit    = (count_reg > CNT_LIMIT) ? CNT_LIMIT : count_reg;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next = mid_sum[FILL_W:1];
    assign q_term   = store_q[ENTRY_W-1 -: TERM_W];
    assign q_clus   = store_q[IMP_W +: CLW];
    assign q_imp    = store_q[IMP_W-1:0];
    assign base     = touched_reg[clus_reg[CLUS_AW-1:0]] ? score_q : '0;
    assign sum      = {1'b0, base} + (SCORE_W + 1)'(prod_reg);
    assign sc_wdata = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
    assign out_free = !out_valid_reg || out_ready;

    assign st_we    = in_acc && (cmd == CMD_LOAD) && (fill_reg != FILL_W'(MAX_POSTINGS))
                      && !((fill_reg != '0) && (term_id < last_term_reg));
    assign st_re    = (state_reg == S_SEARCH) || (state_reg == S_MRD);
    assign st_raddr = (state_reg == S_SEARCH) ? mid_next[POST_AW-1:0] : pos_reg[POST_AW-1:0];
    assign sc_we    = (state_reg == S_ACC);
    assign sc_re    = (state_reg == S_MCHK) || (state_reg == S_SCAN_RD);
    assign sc_raddr = (state_reg == S_MCHK) ? q_clus[CLUS_AW-1:0] : idx_reg[CLUS_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[fill_reg[POST_AW-1:0]] <= {term_id, cluster, impact};
        end
        if (st_re)
        begin
            store_q <= store_mem[st_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_we)
        begin
            score_mem[clus_reg[CLUS_AW-1:0]] <= sc_wdata;
        end
        if (sc_re)
        begin
            score_q <= score_mem[sc_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(q_imp) * PROD_W'(imp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            fill_reg      <= '0;
            err_reg       <= 1'b0;
            touched_reg   <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == REG_NUM_CLUSTERS))
            begin
                count_reg <= pwdata[CNT_W-1:0];
            end
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (cmd)
                            CMD_CLEAR:
                            begin
                                fill_reg    <= '0;
                                err_reg     <= 1'b0;
                                touched_reg <= '0;
                            end
                            CMD_LOAD:
                            begin
                                if (st_we)
                                begin
                                    fill_reg      <= fill_reg + FILL_W'(1);
                                    last_term_reg <= term_id;
                                end
                                else
                                begin
                                    err_reg <= 1'b1;
                                end
                            end
                            CMD_TERM:
                            begin
                                term_reg  <= term_id;
                                imp_reg   <= impact;
                                last_reg  <= last;
                                lo_reg    <= '0;
                                hi_reg    <= fill_reg;
                                state_reg <= S_SEARCH;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid_next;
                        state_reg <= S_SWAIT;
                    end
                    else
                    begin
                        pos_reg   <= lo_reg;
                        state_reg <= S_MRD;
                    end
                end
                S_SWAIT:
                begin
                    if (q_term < term_reg)
                    begin
                        lo_reg <= mid_reg + FILL_W'(1);
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= S_SEARCH;
                end
                S_MRD:
                begin
                    state_reg <= (pos_reg < fill_reg) ? S_MCHK : S_END;
                end
                S_MCHK:
                begin
                    if (q_term != term_reg)
                    begin
                        state_reg <= S_END;
                    end
                    else if ({1'b0, q_clus} < limit)
                    begin
                        clus_reg  <= q_clus;
                        state_reg <= S_ACC;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + FILL_W'(1);
                        state_reg <= S_MRD;
                    end
                end
                S_ACC:
                begin
                    touched_reg[clus_reg[CLUS_AW-1:0]] <= 1'b1;
                    pos_reg   <= pos_reg + FILL_W'(1);
                    state_reg <= S_MRD;
                end
                S_END:
                begin
                    idx_reg    <= '0;
                    found_reg  <= 1'b0;
                    best_c_reg <= '0;
                    best_s_reg <= '0;
                    state_reg  <= last_reg ? S_SCAN_RD : S_IDLE;
                end
                S_SCAN_RD:
                begin
                    state_reg <= (idx_reg < limit) ? S_SCAN_CMP : S_DONE;
                end
                S_SCAN_CMP:
                begin
                    if (touched_reg[idx_reg[CLUS_AW-1:0]] && (!found_reg || score_q > best_s_reg))
                    begin
                        found_reg  <= 1'b1;
                        best_c_reg <= idx_reg[CLW-1:0];
                        best_s_reg <= score_q;
                    end
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_SCAN_RD;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_c_reg     <= best_c_reg;
                        out_s_reg     <= best_s_reg;
                        out_m_reg     <= found_reg;
                        out_e_reg     <= err_reg;
                        touched_reg   <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign win_cluster = out_c_reg;
    assign win_score   = out_s_reg;
    assign matched     = out_m_reg;
    assign load_error  = out_e_reg;
endmodule
`default_nettype wire

// ===== hdl/sdnc_checker.sv =====
// port-level checks for the sparse dot product nearest centroid block
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_dot_nearest_centroid_defines.svh"
module sdnc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [1:0]                    cmd,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [sdnc_pkg::CLW-1:0]      win_cluster,
    input wire logic [sdnc_pkg::SCORE_W-1:0]  win_score,
    input wire logic                          matched,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [sdnc_pkg::PADDR_W-1:0]  paddr,
    input wire logic [sdnc_pkg::PDATA_W-1:0]  prdata,
    input wire logic                          pready
);
    import sdnc_pkg::*;

    `SDNC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SDNC_ASSERT_NOW(a_nomatch_zero, out_valid && !matched, win_cluster == '0 && win_score == '0)
    `SDNC_ASSERT_NEXT(a_term_busy, in_valid && in_ready && cmd == CMD_TERM, !in_ready)
    `SDNC_ASSERT_NOW(a_count_read, psel && !pwrite && paddr[2] == REG_NUM_CLUSTERS,
        prdata[PDATA_W-1:CNT_W] == '0 && pready)
endmodule

bind sparse_dot_nearest_centroid sdnc_checker u_sdnc_checker (.*);
`default_nettype wire
